// ===== design/block_domain_decomposer_unit_assert.svh =====
// Assertion macros shared by the checker of the block domain decomposer.
`ifndef BLOCK_DOMAIN_DECOMPOSER_UNIT_ASSERT_SVH
`define BLOCK_DOMAIN_DECOMPOSER_UNIT_ASSERT_SVH
// Same-cycle implication, disabled while reset is held.
`define BDDU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bdd check failed");
// Next-cycle implication, disabled while reset is held.
`define BDDU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bdd check failed");
`endif

// ===== design/bdd_pkg.sv =====
// Shared constants and types of the block domain decomposer.
package bdd_pkg;
  localparam int MAX_PARTS  = 1024;
  localparam int COORD_BITS = 17;
  localparam int PART_W     = 11;
  localparam int RANK_W     = 10;
  localparam int DIV_NW     = 33;
  localparam int DIV_DW     = 17;
  localparam int DIV_CW     = 6;
  localparam logic [1:0] CFG_X = 2'd0;
  localparam logic [1:0] CFG_Y = 2'd1;
  localparam logic [1:0] CFG_P = 2'd2;
  localparam logic [31:0] HUNDREDTH_Q32 = 32'd42949673;
  localparam logic [17:0] ONE_Q16 = 18'd65536;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [DIV_CW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;
endpackage

// ===== design/bdd_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module bdd_div
  import bdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_NW-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW:0]   trial;
  logic [DIV_CW-1:0] shamt;

  always_comb begin
    trial    = {rem_r, num_r[DIV_NW-1]};
    shamt    = DIV_CW'(DIV_NW) - req.nbits;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      num_nxt  = req.num << shamt;
      den_nxt  = req.den;
      quo_nxt  = '0;
      rem_nxt  = '0;
      cnt_nxt  = req.nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp = '{done: done_r, quo: quo_r, rem: rem_r};
endmodule

// ===== design/block_domain_decomposer_unit.sv =====
// Top level of the block domain decomposer: configuration, sequencer and result registers.
// The result strobe rises once a search over the divisors of P, each put to a ratio check,
// has picked the grid; the block is idle again when the strobe rises.
// An out-of-range rank gives its result in the cycle after the request.
// The shared one-bit-per-cycle divider works every division; one request is worked at a time.
// Synchronous active-low reset restores the registers to 2, 2 and 1 and idles the block.
module block_domain_decomposer_unit
  import bdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [RANK_W-1:0]     in_rank,
  output logic                  out_valid,
  output logic [10:0]           out_cols_used,
  output logic [10:0]           out_rows_used,
  output logic [9:0]            out_col_index,
  output logic [9:0]            out_row_index,
  output logic [16:0]           out_x_first,
  output logic [15:0]           out_x_last,
  output logic [16:0]           out_y_first,
  output logic [15:0]           out_y_last,
  output logic                  out_rank_error
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_ASP = 5'd1,  S_PMOD = 5'd2,  S_NXD = 5'd3;
  localparam logic [4:0] S_NYD  = 5'd4,  S_CHK = 5'd5,  S_R1   = 5'd6,  S_R2  = 5'd7;
  localparam logic [4:0] S_GRID = 5'd8,  S_M1  = 5'd9,  S_M2   = 5'd10, S_M3  = 5'd11;
  localparam logic [4:0] S_M4   = 5'd12, S_M5  = 5'd13, S_PICK = 5'd14, S_ROWS = 5'd15;
  localparam logic [4:0] S_RK   = 5'd16, S_XB  = 5'd17, S_XM   = 5'd18, S_YM1 = 5'd19;
  localparam logic [4:0] S_YM2  = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [COORD_BITS-1:0] x_pts_r, y_pts_r;
  logic [PART_W-1:0] part_cnt_r;
  div_req_t dv_r, dv_nxt;
  div_rsp_t dv_rsp;

  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [PART_W-1:0] p_r, p_nxt, px_r, px_nxt, py_r, py_nxt, fb_r, fb_nxt;
  logic [PART_W-1:0] best_px_r, best_px_nxt, cols_r, cols_nxt, rows_r, rows_nxt;
  logic [16:0] nx_r, nx_nxt, ny_r, ny_nxt, nxf_r, nxf_nxt, nxc_r, nxc_nxt;
  logic [16:0] nyf_r, nyf_nxt, nyc_r, nyc_nxt, xbase_r, xbase_nxt, xrem_r, xrem_nxt;
  logic [16:0] ybase_r, ybase_nxt, yrem_r, yrem_nxt;
  logic [DIV_NW-1:0] aspect_r, aspect_nxt;
  logic [17:0] r1_r, r1_nxt, dev_r, dev_nxt;
  logic found_r, found_nxt;
  logic [63:0] best_cost_r, best_cost_nxt, dd_r, dd_nxt, dev2_r, dev2_nxt, term_r, term_nxt;
  logic [9:0] ix_r, ix_nxt, iy_r, iy_nxt;
  logic [31:0] op_a_r, op_a_nxt, op_b_r, op_b_nxt;
  logic [63:0] prod_r;
  logic out_valid_r, out_valid_nxt, err_r, err_nxt;
  logic [10:0] o_cols_r, o_cols_nxt, o_rows_r, o_rows_nxt;
  logic [9:0] o_ix_r, o_ix_nxt, o_iy_r, o_iy_nxt;
  logic [16:0] o_xf_r, o_xf_nxt, o_yf_r, o_yf_nxt;
  logic [15:0] o_xl_r, o_xl_nxt, o_yl_r, o_yl_nxt;

  logic [PART_W-1:0] p_lim, px_inc, cols_sel;
  logic [16:0] nx_in, ny_in, d1, d2, nq17, nr17;
  logic [17:0] rmax, first18, last18, mn18;
  logic [DIV_NW-1:0] gdiff;
  logic [31:0] dsat;
  logic [11:0] fsum;
  logic [23:0] fsq;
  logic [63:0] cost;
  logic adv_last, ok1, ok2;

  assign p_lim = (part_cnt_r > PART_W'(MAX_PARTS)) ? PART_W'(MAX_PARTS) : part_cnt_r;
  assign nx_in = (x_pts_r < 17'd2) ? 17'd1 : x_pts_r - 17'd1;
  assign ny_in = (y_pts_r < 17'd2) ? 17'd1 : y_pts_r - 17'd1;
  assign px_inc = px_r + 1'b1;
  assign adv_last = (px_r == p_r);
  assign nq17 = dv_rsp.quo[16:0];
  assign nr17 = dv_rsp.rem;
  assign d1 = (nyf_r == 17'd0) ? 17'd1 : nyf_r;
  assign d2 = (nyc_r == 17'd0) ? 17'd1 : nyc_r;
  assign ok1 = ({1'b0, nxc_r} <= {d1, 1'b0}) && ({nxc_r, 1'b0} >= {1'b0, d1});
  assign ok2 = ({1'b0, nxf_r} <= {d2, 1'b0}) && ({nxf_r, 1'b0} >= {1'b0, d2});
  assign rmax = (r1_r > dv_rsp.quo[17:0]) ? r1_r : dv_rsp.quo[17:0];
  assign gdiff = (dv_rsp.quo >= aspect_r) ? dv_rsp.quo - aspect_r : aspect_r - dv_rsp.quo;
  assign dsat = gdiff[DIV_NW-1] ? 32'hFFFF_FFFF : gdiff[31:0];
  assign fsum = {1'b0, px_r} + {1'b0, fb_r};
  assign fsq = fsum * fsum;
  assign cost = dev2_r + term_r + {32'd0, prod_r[63:32]};
  assign cols_sel = found_r ? best_px_r : fb_r;

  bdd_div u_div (.clk(clk), .rst_n(rst_n), .req(dv_r), .rsp(dv_rsp));

  always_comb begin
    state_nxt = state_r;  dv_nxt = dv_r;  dv_nxt.start = 1'b0;
    rank_nxt = rank_r;  p_nxt = p_r;  px_nxt = px_r;  py_nxt = py_r;  fb_nxt = fb_r;
    best_px_nxt = best_px_r;  cols_nxt = cols_r;  rows_nxt = rows_r;
    nx_nxt = nx_r;  ny_nxt = ny_r;  nxf_nxt = nxf_r;  nxc_nxt = nxc_r;
    nyf_nxt = nyf_r;  nyc_nxt = nyc_r;  xbase_nxt = xbase_r;  xrem_nxt = xrem_r;
    ybase_nxt = ybase_r;  yrem_nxt = yrem_r;  aspect_nxt = aspect_r;
    r1_nxt = r1_r;  dev_nxt = dev_r;  found_nxt = found_r;  best_cost_nxt = best_cost_r;
    dd_nxt = dd_r;  dev2_nxt = dev2_r;  term_nxt = term_r;  ix_nxt = ix_r;  iy_nxt = iy_r;
    op_a_nxt = op_a_r;  op_b_nxt = op_b_r;  out_valid_nxt = 1'b0;  err_nxt = err_r;
    o_cols_nxt = o_cols_r;  o_rows_nxt = o_rows_r;  o_ix_nxt = o_ix_r;  o_iy_nxt = o_iy_r;
    o_xf_nxt = o_xf_r;  o_xl_nxt = o_xl_r;  o_yf_nxt = o_yf_r;  o_yl_nxt = o_yl_r;
    mn18 = '0;  first18 = '0;  last18 = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          rank_nxt = in_rank;
          p_nxt = p_lim;
          nx_nxt = nx_in;
          ny_nxt = ny_in;
          if ({1'b0, in_rank} >= p_lim) begin
            out_valid_nxt = 1'b1;  err_nxt = 1'b1;
            o_cols_nxt = '0;  o_rows_nxt = '0;  o_ix_nxt = '0;  o_iy_nxt = '0;
            o_xf_nxt = '0;  o_xl_nxt = '0;  o_yf_nxt = '0;  o_yl_nxt = '0;
          end else begin
            dv_nxt = '{start: 1'b1, num: {nx_in, 16'd0}, den: ny_in, nbits: DIV_CW'(33)};
            state_nxt = S_ASP;
          end
        end
      end
      S_ASP: begin
        if (dv_rsp.done) begin
          aspect_nxt = dv_rsp.quo;
          px_nxt = PART_W'(1);  fb_nxt = PART_W'(1);  found_nxt = 1'b0;
          dv_nxt = '{start: 1'b1, num: DIV_NW'(p_r), den: DIV_DW'(1), nbits: DIV_CW'(11)};
          state_nxt = S_PMOD;
        end
      end
      S_PMOD: begin
        if (dv_rsp.done) begin
          if (nr17 != 17'd0) begin
            if (adv_last) begin
              state_nxt = S_PICK;
            end else begin
              px_nxt = px_inc;
              dv_nxt = '{start: 1'b1, num: DIV_NW'(p_r), den: DIV_DW'(px_inc),
                         nbits: DIV_CW'(11)};
            end
          end else begin
            if (px_r >= PART_W'(2) && fsq < {11'd0, p_r, 2'b00}) fb_nxt = px_r;
            py_nxt = dv_rsp.quo[PART_W-1:0];
            dv_nxt = '{start: 1'b1, num: DIV_NW'(nx_r), den: DIV_DW'(px_r), nbits: DIV_CW'(17)};
            state_nxt = S_NXD;
          end
        end
      end
      S_NXD: begin
        if (dv_rsp.done) begin
          nxf_nxt = nq17;
          nxc_nxt = nq17 + {16'd0, (nr17 != 17'd0)};
          dv_nxt = '{start: 1'b1, num: DIV_NW'(ny_r), den: DIV_DW'(py_r), nbits: DIV_CW'(17)};
          state_nxt = S_NYD;
        end
      end
      S_NYD: begin
        if (dv_rsp.done) begin
          nyf_nxt = nq17;
          nyc_nxt = nq17 + {16'd0, (nr17 != 17'd0)};
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (ok1 && ok2) begin
          dv_nxt = '{start: 1'b1, num: {nxc_r, 16'd0}, den: d1, nbits: DIV_CW'(33)};
          state_nxt = S_R1;
        end else if (adv_last) begin
          state_nxt = S_PICK;
        end else begin
          px_nxt = px_inc;
          dv_nxt = '{start: 1'b1, num: DIV_NW'(p_r), den: DIV_DW'(px_inc), nbits: DIV_CW'(11)};
          state_nxt = S_PMOD;
        end
      end
      S_R1: begin
        if (dv_rsp.done) begin
          r1_nxt = dv_rsp.quo[17:0];
          dv_nxt = '{start: 1'b1, num: {nxf_r, 16'd0}, den: d2, nbits: DIV_CW'(33)};
          state_nxt = S_R2;
        end
      end
      S_R2: begin
        if (dv_rsp.done) begin
          dev_nxt = (rmax >= ONE_Q16) ? rmax - ONE_Q16 : ONE_Q16 - rmax;
          dv_nxt = '{start: 1'b1, num: {6'd0, px_r, 16'd0}, den: DIV_DW'(py_r),
                     nbits: DIV_CW'(27)};
          state_nxt = S_GRID;
        end
      end
      S_GRID: begin
        if (dv_rsp.done) begin
          op_a_nxt = dsat;  op_b_nxt = dsat;
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        op_a_nxt = {14'd0, dev_r};  op_b_nxt = {14'd0, dev_r};
        state_nxt = S_M2;
      end
      S_M2: begin
        dd_nxt = prod_r;
        op_a_nxt = prod_r[63:32];  op_b_nxt = HUNDREDTH_Q32;
        state_nxt = S_M3;
      end
      S_M3: begin
        dev2_nxt = prod_r;
        op_a_nxt = dd_r[31:0];  op_b_nxt = HUNDREDTH_Q32;
        state_nxt = S_M4;
      end
      S_M4: begin
        term_nxt = prod_r;
        state_nxt = S_M5;
      end
      S_M5: begin
        if (!found_r || cost < best_cost_r) begin
          found_nxt = 1'b1;  best_cost_nxt = cost;  best_px_nxt = px_r;
        end
        if (adv_last) begin
          state_nxt = S_PICK;
        end else begin
          px_nxt = px_inc;
          dv_nxt = '{start: 1'b1, num: DIV_NW'(p_r), den: DIV_DW'(px_inc), nbits: DIV_CW'(11)};
          state_nxt = S_PMOD;
        end
      end
      S_PICK: begin
        cols_nxt = cols_sel;
        dv_nxt = '{start: 1'b1, num: DIV_NW'(p_r), den: DIV_DW'(cols_sel), nbits: DIV_CW'(11)};
        state_nxt = S_ROWS;
      end
      S_ROWS: begin
        if (dv_rsp.done) begin
          rows_nxt = dv_rsp.quo[PART_W-1:0];
          dv_nxt = '{start: 1'b1, num: DIV_NW'(rank_r), den: DIV_DW'(cols_r),
                     nbits: DIV_CW'(10)};
          state_nxt = S_RK;
        end
      end
      S_RK: begin
        if (dv_rsp.done) begin
          iy_nxt = dv_rsp.quo[9:0];
          ix_nxt = dv_rsp.rem[9:0];
          dv_nxt = '{start: 1'b1, num: DIV_NW'(nx_r), den: DIV_DW'(cols_r), nbits: DIV_CW'(17)};
          state_nxt = S_XB;
        end
      end
      S_XB: begin
        if (dv_rsp.done) begin
          xbase_nxt = nq17;  xrem_nxt = nr17;
          op_a_nxt = {22'd0, ix_r};  op_b_nxt = {15'd0, nq17};
          dv_nxt = '{start: 1'b1, num: DIV_NW'(ny_r), den: DIV_DW'(rows_r), nbits: DIV_CW'(17)};
          state_nxt = S_XM;
        end
      end
      S_XM: begin
        if (dv_rsp.done) begin
          mn18 = ({7'd0, ix_r} < xrem_r) ? {8'd0, ix_r} : {1'b0, xrem_r};
          first18 = 18'd1 + prod_r[17:0] + mn18;
          last18 = first18 + {1'b0, xbase_r} + {17'd0, ({7'd0, ix_r} < xrem_r)} - 18'd1;
          o_xf_nxt = first18[16:0];
          o_xl_nxt = last18[15:0];
          ybase_nxt = nq17;  yrem_nxt = nr17;
          op_a_nxt = {22'd0, iy_r};  op_b_nxt = {15'd0, nq17};
          state_nxt = S_YM1;
        end
      end
      S_YM1: begin
        state_nxt = S_YM2;
      end
      S_YM2: begin
        mn18 = ({7'd0, iy_r} < yrem_r) ? {8'd0, iy_r} : {1'b0, yrem_r};
        first18 = 18'd1 + prod_r[17:0] + mn18;
        last18 = first18 + {1'b0, ybase_r} + {17'd0, ({7'd0, iy_r} < yrem_r)} - 18'd1;
        o_yf_nxt = first18[16:0];
        o_yl_nxt = last18[15:0];
        o_cols_nxt = cols_r;  o_rows_nxt = rows_r;  o_ix_nxt = ix_r;  o_iy_nxt = iy_r;
        err_nxt = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_pts_r     <= 17'd2;
      y_pts_r     <= 17'd2;
      part_cnt_r  <= 11'd1;
      dv_r.start  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r.start  <= dv_nxt.start;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_X: x_pts_r <= cfg_data;
          CFG_Y: y_pts_r <= cfg_data;
          CFG_P: part_cnt_r <= cfg_data[PART_W-1:0];
          default: ;
        endcase
      end
    end
    dv_r.num <= dv_nxt.num;  dv_r.den <= dv_nxt.den;  dv_r.nbits <= dv_nxt.nbits;
    rank_r <= rank_nxt;  p_r <= p_nxt;  px_r <= px_nxt;  py_r <= py_nxt;  fb_r <= fb_nxt;
    best_px_r <= best_px_nxt;  cols_r <= cols_nxt;  rows_r <= rows_nxt;
    nx_r <= nx_nxt;  ny_r <= ny_nxt;  nxf_r <= nxf_nxt;  nxc_r <= nxc_nxt;
    nyf_r <= nyf_nxt;  nyc_r <= nyc_nxt;  xbase_r <= xbase_nxt;  xrem_r <= xrem_nxt;
    ybase_r <= ybase_nxt;  yrem_r <= yrem_nxt;  aspect_r <= aspect_nxt;
    r1_r <= r1_nxt;  dev_r <= dev_nxt;  found_r <= found_nxt;  best_cost_r <= best_cost_nxt;
    dd_r <= dd_nxt;  dev2_r <= dev2_nxt;  term_r <= term_nxt;  ix_r <= ix_nxt;  iy_r <= iy_nxt;
    op_a_r <= op_a_nxt;  op_b_r <= op_b_nxt;  prod_r <= op_a_r * op_b_r;
    err_r <= err_nxt;  o_cols_r <= o_cols_nxt;  o_rows_r <= o_rows_nxt;
    o_ix_r <= o_ix_nxt;  o_iy_r <= o_iy_nxt;  o_xf_r <= o_xf_nxt;  o_xl_r <= o_xl_nxt;
    o_yf_r <= o_yf_nxt;  o_yl_r <= o_yl_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_rank_error = err_r;
  assign out_cols_used  = o_cols_r;
  assign out_rows_used  = o_rows_r;
  assign out_col_index  = o_ix_r;
  assign out_row_index  = o_iy_r;
  assign out_x_first    = o_xf_r;
  assign out_x_last     = o_xl_r;
  assign out_y_first    = o_yf_r;
  assign out_y_last     = o_yl_r;
endmodule

// ===== design/bdd_checker.sv =====
// Port-level checker of the block domain decomposer and its bind statement.
`include "block_domain_decomposer_unit_assert.svh"
module bdd_checker
  import bdd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_rank_error,
  input logic [10:0] out_cols_used,
  input logic [10:0] out_rows_used
);
  `BDDU_ASSERT_NEXT(a_req_taken, clk, rst_n, start && !busy, busy || out_valid)
  `BDDU_ASSERT_SAME(a_result_idle, clk, rst_n, out_valid, !busy)
  `BDDU_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && out_rank_error, out_cols_used == 11'd0)
  `BDDU_ASSERT_SAME(a_grid_nonzero, clk, rst_n, out_valid && !out_rank_error, out_rows_used != 0)
endmodule

bind block_domain_decomposer_unit bdd_checker u_bdd_checker (.*);
